>>> design/ump_pkg.sv
// Shared types and constants for the unicycle motion predictor.
`default_nettype none
package ump_pkg;
  localparam int ANG_BITS = 30;
  localparam logic [31:0] INV_HALF_PI_Q32 = 32'd2734261102;
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam int ATAN_ENTRIES = 31;

  function automatic logic signed [33:0] atan_q30(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd843314857;
      1: r = 34'sd497837829;
      2: r = 34'sd263043837;
      3: r = 34'sd133525159;
      4: r = 34'sd67021687;
      5: r = 34'sd33543516;
      6: r = 34'sd16775851;
      7: r = 34'sd8388437;
      8: r = 34'sd4194283;
      9: r = 34'sd2097149;
      default: r = (i < ATAN_ENTRIES) ? (34'sd1 <<< (30 - i)) : 34'sd0;
    endcase
    return r;
  endfunction

  // side data carried alongside the angle path
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] speed;
    logic signed [31:0] turn_rate;
    logic [23:0]        time_step;
    logic [1:0]         quad;
    logic               r_neg;
    logic               h_neg;
  } side_t;
endpackage
`default_nettype wire

>>> design/ump_reduce.sv
// Heading range reduction to quadrant and residual angle (three stages).
`default_nettype none
module ump_reduce #(
  parameter int FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_valid,
  input  wire ump_pkg::side_t in_side,
  output logic              out_valid,
  output ump_pkg::side_t    out_side,
  output logic signed [33:0] out_z
);
  localparam int FB = FRAC_BITS + 32;

  logic [1:0] v;
  ump_pkg::side_t s1, s2, s1_next, s2_next;
  logic [63:0] p1;
  logic [30:0] fq2;
  logic [32:0] a0;
  logic [63:0] base;
  logic [63:0] fmag;
  logic [63:0] kk;
  logic [61:0] zp;

  always_comb begin
    a0 = in_side.heading[31] ? (33'd0 - {in_side.heading[31], in_side.heading})
                             : {1'b0, in_side.heading};
    kk = (p1 + (64'd1 << (FB - 1))) >> FB;
    base = kk << FB;
    fmag = (p1 < base) ? (base - p1) : (p1 - base);
    zp = 62'(fq2) * 62'(ump_pkg::HALF_PI_Q30);
    s1_next = in_side;
    s1_next.h_neg = in_side.heading[31];
    s2_next = s1;
    s2_next.quad = kk[1:0];
    s2_next.r_neg = p1 < base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[0], in_valid};
      out_valid <= v[1];
    end
    if (en) begin
      p1 <= 64'(a0) * 64'(ump_pkg::INV_HALF_PI_Q32);
      s1 <= s1_next;
      s2 <= s2_next;
      fq2 <= 31'(fmag >> (FRAC_BITS + 2));
      out_side <= s2;
      out_z <= 34'(zp >> ump_pkg::ANG_BITS);
    end
  end
endmodule
`default_nettype wire

>>> design/ump_cordic.sv
// Pipelined rotation-mode CORDIC, one stage per register.
`default_nettype none
module ump_cordic #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_valid,
  input  wire ump_pkg::side_t in_side,
  input  wire signed [33:0] in_z,
  output logic              out_valid,
  output ump_pkg::side_t    out_side,
  output logic signed [33:0] out_cos,
  output logic signed [33:0] out_sin
);
  localparam int N = (CORDIC_STAGES < ump_pkg::ATAN_ENTRIES) ? CORDIC_STAGES
                                                             : ump_pkg::ATAN_ENTRIES;
  // entry i holds the output of stage i
  logic [N-1:0] v;
  logic signed [33:0] xr [N];
  logic signed [33:0] yr [N];
  logic signed [33:0] zr [N];
  ump_pkg::side_t sr [N];

  always_ff @(posedge clk) begin
    if (rst) v <= '0;
    else if (en) v <= {v[N-2:0], in_valid};
    if (en) begin
      // first stage starts from x = gain, y = 0
      sr[0] <= in_side;
      xr[0] <= ump_pkg::CORDIC_GAIN_Q30;
      if (!in_z[33]) begin
        yr[0] <= ump_pkg::CORDIC_GAIN_Q30;
        zr[0] <= in_z - ump_pkg::atan_q30(0);
      end else begin
        yr[0] <= -ump_pkg::CORDIC_GAIN_Q30;
        zr[0] <= in_z + ump_pkg::atan_q30(0);
      end
      for (int i = 1; i < N; i++) begin
        sr[i] <= sr[i-1];
        if (!zr[i-1][33]) begin
          xr[i] <= xr[i-1] - (yr[i-1] >>> i);
          yr[i] <= yr[i-1] + (xr[i-1] >>> i);
          zr[i] <= zr[i-1] - ump_pkg::atan_q30(i);
        end else begin
          xr[i] <= xr[i-1] + (yr[i-1] >>> i);
          yr[i] <= yr[i-1] - (xr[i-1] >>> i);
          zr[i] <= zr[i-1] + ump_pkg::atan_q30(i);
        end
      end
    end
  end

  // quadrant and sign fix-up, registered
  logic signed [33:0] s0, c, s;
  always_comb begin
    s0 = sr[N-1].r_neg ? -yr[N-1] : yr[N-1];
    case (sr[N-1].quad)
      2'd0: begin c = xr[N-1]; s = s0; end
      2'd1: begin c = -s0; s = xr[N-1]; end
      2'd2: begin c = -xr[N-1]; s = -s0; end
      default: begin c = s0; s = -xr[N-1]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v[N-1];
    if (en) begin
      out_side <= sr[N-1];
      out_cos <= c;
      out_sin <= sr[N-1].h_neg ? -s : s;
    end
  end
endmodule
`default_nettype wire

>>> design/ump_kin.sv
// Speed and time-step products, sums and saturation (three stages).
`default_nettype none
module ump_kin #(
  parameter int FRAC_BITS = 16
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               en,
  input  wire               in_valid,
  input  wire ump_pkg::side_t in_side,
  input  wire signed [33:0] in_cos,
  input  wire signed [33:0] in_sin,
  output logic              out_valid,
  output logic [160:0]      out_data
);
  logic [1:0] v;
  ump_pkg::side_t s1;
  logic signed [66:0] pc, ps;
  logic signed [56:0] pw;
  logic signed [36:0] vc, vs;
  logic signed [63:0] vcdt_p, vsdt_p;
  logic signed [31:0] px2, py2, h2;
  logic signed [56:0] pw2;
  logic signed [63:0] vcdt, vsdt, wdt, sx, sy, sh, jx;
  logic [31:0] o0, o1, o2, o3, o4;
  logic f;

  function automatic logic [31:0] sat(input logic signed [63:0] x, inout logic fl);
    logic [31:0] r;
    if (x > 64'sd2147483647) begin r = 32'h7fffffff; fl = 1'b1; end
    else if (x < -64'sd2147483648) begin r = 32'h80000000; fl = 1'b1; end
    else r = x[31:0];
    return r;
  endfunction

  always_comb begin
    vc = 37'((pc + (67'sd1 <<< 29)) >>> 30);
    vs = 37'((ps + (67'sd1 <<< 29)) >>> 30);
    vcdt = (vcdt_p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    vsdt = (vsdt_p + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    wdt = 64'((pw2 + (57'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
    sx = 64'(px2) + vcdt;
    sy = 64'(py2) + vsdt;
    sh = 64'(h2) + wdt;
    jx = -vsdt;
    f = 1'b0;
    o0 = sat(sx, f);
    o1 = sat(sy, f);
    o2 = sat(sh, f);
    o3 = sat(jx, f);
    o4 = sat(vcdt, f);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v <= {v[0], in_valid};
      out_valid <= v[1];
    end
    if (en) begin
      pc <= 67'(in_side.speed) * 67'(in_cos);
      ps <= 67'(in_side.speed) * 67'(in_sin);
      pw <= 57'(in_side.turn_rate) * $signed({33'd0, in_side.time_step});
      s1 <= in_side;
      vcdt_p <= 64'(vc) * $signed({40'd0, s1.time_step});
      vsdt_p <= 64'(vs) * $signed({40'd0, s1.time_step});
      pw2 <= pw;
      px2 <= s1.pos_x;
      py2 <= s1.pos_y;
      h2 <= s1.heading;
      out_data <= {f, o4, o3, o2, o1, o0};
    end
  end
endmodule
`default_nettype wire

>>> design/unicycle_motion_predict_top.sv
// Top level of the unicycle motion predictor with EKF Jacobian entries.
`default_nettype none
// Unicycle pose predictor. Each request carries a pose, speed, turn rate and
// time step; each result gives the next pose, the two heading Jacobian terms
// and a saturation flag. Fully pipelined: one request per cycle while not
// stalled, through range reduction, the CORDIC stage chain, the quadrant
// fix and the products and saturation. The whole pipe advances when the
// output register is empty or being taken, so a stall holds every stage.
// Angles use 30 fraction bits internally; heading out is not wrapped.
module unicycle_motion_predict_top #(
  parameter int CORDIC_STAGES = 16,
  parameter int FRAC_BITS = 16
) (
  input  wire          clk,
  input  wire          rst,
  input  wire          s_tvalid,
  output logic         s_tready,
  // pos_x, pos_y, heading, speed, turn_rate, time_step
  input  wire [183:0]  s_tdata,
  output logic         m_tvalid,
  input  wire          m_tready,
  // next_x, next_y, next_heading, jac_x_heading, jac_y_heading
  output logic [159:0] m_tdata,
  // saturated
  output logic         m_tuser
);
  logic en;
  ump_pkg::side_t side_in, rs, cs;
  logic rv, cv;
  logic signed [33:0] rz, cc, sn;
  logic [160:0] kd;

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  always_comb begin
    side_in = '0;
    side_in.pos_x = s_tdata[31:0];
    side_in.pos_y = s_tdata[63:32];
    side_in.heading = s_tdata[95:64];
    side_in.speed = s_tdata[127:96];
    side_in.turn_rate = s_tdata[159:128];
    side_in.time_step = s_tdata[183:160];
  end

  ump_reduce #(.FRAC_BITS(FRAC_BITS)) u_reduce (
    .clk, .rst, .en, .in_valid(s_tvalid), .in_side(side_in),
    .out_valid(rv), .out_side(rs), .out_z(rz));

  ump_cordic #(.CORDIC_STAGES(CORDIC_STAGES)) u_cordic (
    .clk, .rst, .en, .in_valid(rv), .in_side(rs), .in_z(rz),
    .out_valid(cv), .out_side(cs), .out_cos(cc), .out_sin(sn));

  ump_kin #(.FRAC_BITS(FRAC_BITS)) u_kin (
    .clk, .rst, .en, .in_valid(cv), .in_side(cs), .in_cos(cc), .in_sin(sn),
    .out_valid(m_tvalid), .out_data(kd));

  assign m_tdata = kd[159:0];
  assign m_tuser = kd[160];

  // stalled result must hold
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");
  // a valid result never carries unknown bits
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !$isunknown({m_tuser, m_tdata}))
    else $error("result has unknown bits");
  // ready follows the output register
  assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("pipe stalled while empty");
endmodule
`default_nettype wire

>>> tb/tb_unicycle_motion_predict_top.sv
// Self-checking testbench for the unicycle motion predictor.
`default_nettype none
module tb_unicycle_motion_predict_top;
  localparam int STAGES = 16;
  localparam int FB = 16;
  localparam int PIPE_DEPTH = 3 + STAGES + 1 + 3;
  localparam longint unsigned CYCLE_LIMIT = 400000;

  // one pose request
  typedef struct packed {
    logic [23:0]        time_step;
    logic signed [31:0] turn_rate;
    logic signed [31:0] speed;
    logic signed [31:0] heading;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_x;
  } pose_req_t;

  // one predicted pose
  typedef struct packed {
    logic               saturated;
    logic signed [31:0] jac_y_heading;
    logic signed [31:0] jac_x_heading;
    logic signed [31:0] next_heading;
    logic signed [31:0] next_y;
    logic signed [31:0] next_x;
  } pose_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic [183:0] s_tdata = '0;
  logic m_tready = 1'b0;
  logic s_tready, m_tvalid, m_tuser;
  logic [159:0] m_tdata;

  always #1 clk = ~clk;

  unicycle_motion_predict_top #(.CORDIC_STAGES(STAGES), .FRAC_BITS(FB)) u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  pose_req_t pending_reqs[$];
  pose_res_t expected_poses[$];
  int error_count = 0;
  longint unsigned cycle_count = 0;
  bit stim_done = 1'b0;
  bit drain_pause = 1'b0;   // sender waits for the pipe to empty
  bit quiet_tail = 1'b0;    // last part of the run: no idling
  bit long_hold = 1'b0;     // receiver hold-off in progress

  // add half, then floor shift of a signed 128-bit value
  function automatic logic signed [127:0] round_shift(logic signed [127:0] v, int n);
    logic signed [127:0] t;
    t = v + (128'sd1 <<< (n - 1));
    return t >>> n;
  endfunction

  function automatic logic signed [31:0] clip32(logic signed [127:0] v, ref bit flag);
    if (v > 128'sd2147483647) begin
      flag = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      flag = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [63:0] atan_entry(int i);
    logic signed [63:0] tab [0:9];
    tab = '{64'sd843314857, 64'sd497837829, 64'sd263043837, 64'sd133525159,
            64'sd67021687, 64'sd33543516, 64'sd16775851, 64'sd8388437,
            64'sd4194283, 64'sd2097149};
    if (i < 10) return tab[i];
    return 64'sd1 <<< (30 - i);
  endfunction

  // cos/sin of the heading, 30 fraction bits
  function automatic void heading_sincos(logic signed [31:0] h,
                                         output logic signed [63:0] c_o,
                                         output logic signed [63:0] s_o);
    bit h_neg, r_neg;
    logic [63:0] a, p, k, base, fmag, fq30;
    logic [127:0] zp;
    logic signed [63:0] x, y, z, xs, ys, c0, s0, c, s;
    h_neg = (h < 0);
    a = h_neg ? 64'(-64'(h)) : 64'(h);
    p = a * 64'd2734261102;
    k = (p + (64'd1 << (FB + 31))) >> (FB + 32);
    base = k << (FB + 32);
    r_neg = (p < base);
    fmag = r_neg ? base - p : p - base;
    fq30 = fmag >> (FB + 2);
    zp = 128'(fq30) * 128'd1686629713;
    z = 64'(zp >> 30);
    x = 64'sd652032874;
    y = '0;
    for (int i = 0; i < STAGES && i < 31; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - atan_entry(i);
      end else begin
        x = x + ys; y = y - xs; z = z + atan_entry(i);
      end
    end
    c0 = x;
    s0 = r_neg ? -y : y;
    case (k[1:0])
      2'd0: begin c = c0; s = s0; end
      2'd1: begin c = -s0; s = c0; end
      2'd2: begin c = -c0; s = -s0; end
      default: begin c = s0; s = -c0; end
    endcase
    c_o = c;
    s_o = h_neg ? -s : s;
  endfunction

  function automatic pose_res_t predict_pose(pose_req_t q);
    pose_res_t r;
    logic signed [63:0] c, s;
    logic signed [127:0] vc, vs, vcdt, vsdt, wdt, dt;
    bit flag;
    flag = 1'b0;
    heading_sincos(q.heading, c, s);
    dt = 128'(q.time_step);
    vc = round_shift(128'(q.speed) * 128'(c), 30);
    vs = round_shift(128'(q.speed) * 128'(s), 30);
    vcdt = round_shift(vc * dt, FB);
    vsdt = round_shift(vs * dt, FB);
    wdt = round_shift(128'(q.turn_rate) * dt, FB);
    r.next_x = clip32(128'(q.pos_x) + vcdt, flag);
    r.next_y = clip32(128'(q.pos_y) + vsdt, flag);
    r.next_heading = clip32(128'(q.heading) + wdt, flag);
    r.jac_x_heading = clip32(-vsdt, flag);
    r.jac_y_heading = clip32(vcdt, flag);
    r.saturated = flag;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
    error_count++;
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'(int'($urandom_range(0, 400000)) - 200000);
      3, 4: return 32'(int'($urandom_range(0, 40000000)) - 20000000);
      default: return $urandom;
    endcase
  endfunction

  function automatic pose_req_t rand_req();
    pose_req_t q;
    q.pos_x = rand_word();
    q.pos_y = rand_word();
    q.heading = ($urandom_range(0, 2) == 0) ? rand_word()
                : 32'(int'($urandom_range(0, 1700000)) - 850000);
    q.speed = ($urandom_range(0, 2) == 0) ? rand_word()
              : 32'(int'($urandom_range(0, 4000000)) - 2000000);
    q.turn_rate = rand_word();
    case ($urandom_range(0, 3))
      0: q.time_step = 24'($urandom);
      1: q.time_step = 24'($urandom_range(0, 65536));
      default: q.time_step = 24'($urandom_range(0, 8000));
    endcase
    return q;
  endfunction

  // driver: offers queued requests, idling in bursts
  int send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        void'(pending_reqs.pop_front());
      end
      if (send_gap > 0) send_gap <= send_gap - 1;
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (drain_pause || pending_reqs.size() == 0) begin
        s_tvalid <= 1'b0;
      end else if (send_gap == 0 && !quiet_tail && $urandom_range(0, 19) == 0) begin
        s_tvalid <= 1'b0;
        send_gap <= $urandom_range(1, 14);
      end else if (send_gap > 1 && !quiet_tail) begin
        s_tvalid <= 1'b0;
      end else begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_reqs[0];
        expected_poses.push_back(predict_pose(pending_reqs[0]));
      end
    end
  end

  // monitor: takes results with random stalls and checks them in order
  int recv_gap = 0;
  always @(posedge clk) begin
    pose_res_t got, want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tuser, m_tdata};
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected result", got.next_x, 32'd0);
        end else begin
          want = expected_poses.pop_front();
          if (got.next_x !== want.next_x) report_mismatch("next_x", got.next_x, want.next_x);
          if (got.next_y !== want.next_y) report_mismatch("next_y", got.next_y, want.next_y);
          if (got.next_heading !== want.next_heading)
            report_mismatch("next_heading", got.next_heading, want.next_heading);
          if (got.jac_x_heading !== want.jac_x_heading)
            report_mismatch("jac_x_heading", got.jac_x_heading, want.jac_x_heading);
          if (got.jac_y_heading !== want.jac_y_heading)
            report_mismatch("jac_y_heading", got.jac_y_heading, want.jac_y_heading);
          if (got.saturated !== want.saturated)
            report_mismatch("saturated", 32'(got.saturated), 32'(want.saturated));
        end
      end
      if (recv_gap > 0) recv_gap <= recv_gap - 1;
      if (long_hold) begin
        m_tready <= 1'b0;
      end else if (quiet_tail) begin
        m_tready <= 1'b1;
      end else if (recv_gap == 0 && $urandom_range(0, 19) == 0) begin
        m_tready <= 1'b0;
        recv_gap <= $urandom_range(1, 14);
      end else begin
        m_tready <= (recv_gap <= 1);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pose_req_t q;
    logic [31:0] edge_vals [0:4];
    edge_vals = '{32'h00000000, 32'h7fffffff, 32'h80000000, 32'hffffffff, 32'h00010000};
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: field extremes, zero step, heading quadrants and huge headings
    for (int i = 0; i < 5; i++) begin
      q.pos_x = edge_vals[i];
      q.pos_y = edge_vals[(i + 1) % 5];
      q.heading = edge_vals[(i + 2) % 5];
      q.speed = edge_vals[(i + 3) % 5];
      q.turn_rate = edge_vals[(i + 4) % 5];
      q.time_step = (i % 2) ? 24'hffffff : 24'h000000;
      pending_reqs.push_back(q);
    end
    for (int i = -8; i <= 8; i++) begin
      q.pos_x = '0; q.pos_y = '0;
      q.heading = 32'(i * 25736);       // steps of about pi/8
      q.speed = 32'sh00010000;
      q.turn_rate = 32'sh00008000;
      q.time_step = 24'h010000;
      pending_reqs.push_back(q);
    end
    q.heading = 32'h7fffffff; q.speed = 32'h7fffffff; q.time_step = 24'hffffff;
    pending_reqs.push_back(q);

    // random traffic; a long receiver hold-off while the sender keeps going
    for (int i = 0; i < 900; i++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() < 700);
    @(posedge clk);
    long_hold <= 1'b1;
    repeat (300) @(posedge clk);
    long_hold <= 1'b0;
    wait (pending_reqs.size() == 0);

    // sender pause until the pipe drains
    drain_pause = 1'b1;
    wait (expected_poses.size() == 0);
    @(posedge clk);
    drain_pause = 1'b0;

    for (int i = 0; i < 700; i++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() == 0);

    // last part: no idling on either side
    quiet_tail = 1'b1;
    for (int i = 0; i < 300; i++) pending_reqs.push_back(rand_req());
    wait (pending_reqs.size() == 0);
    wait (expected_poses.size() == 0);
    repeat (PIPE_DEPTH + 10) @(posedge clk);
    if (error_count == 0 && expected_poses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
design/ump_pkg.sv
design/ump_reduce.sv
design/ump_cordic.sv
design/ump_kin.sv
design/unicycle_motion_predict_top.sv
tb/tb_unicycle_motion_predict_top.sv
